FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge
`define USV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// prop must never hold at a clock edge
`define USV_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) not (prop)) else $error(msg);

`endif

FILE: sv/usv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_pkg
// Types and codes shared by the unique value set controller and datapath.
// ---------------------------------------------------------------------------
package usv_pkg;

  localparam int unsigned ActW  = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 7;
  localparam int unsigned StatW = 3;
  localparam int unsigned CntOutW = 6;

  localparam logic [ActW-1:0] ACT_ADD    = 2'd0;
  localparam logic [ActW-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActW-1:0] ACT_READ   = 2'd2;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_REM_SCAN,
    S_REM_LAST,
    S_REM_MOVE,
    S_RD_ADDR,
    S_RD_DATA
  } state_e;

  typedef enum logic [1:0] {
    ADDR_SCAN,
    ADDR_LAST,
    ADDR_INDEX
  } addr_sel_e;

  typedef enum logic {
    WR_APPEND,
    WR_MOVE
  } wr_sel_e;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      pos_load;
    logic      res_load;
    status_e   res_status;
    logic      res_data;
  } usv_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic scan_done;
  } usv_stat_t;

endpackage

FILE: sv/unique_value_set.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unique_value_set
// Set of distinct signed 32-bit values with add, remove and indexed read.
// ---------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Its result
// shows on status_o, read_value_o and entry_count_o for one cycle with done_o
// high, and must be taken then. Add and remove scan the N entries in use, one
// per cycle, through the single read port of the entry store. Add stops at a
// duplicate and remove at the matching entry; remove then reads the last entry
// and writes it into the hole. Read reads the indexed entry and then registers
// it as the result. Read of an empty set and the unused action code answer
// without leaving idle. busy drops in the cycle that shows the result, so the
// next request may be taken there. entry_count_o carries the low 6 bits of the
// count.
module unique_value_set #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [usv_pkg::ActW-1:0]          action_i,
  input  logic signed [usv_pkg::DataW-1:0]  value_i,
  input  logic signed [usv_pkg::IdxW-1:0]   index_i,
  output logic                              done_o,
  output logic [usv_pkg::StatW-1:0]         status_o,
  output logic signed [usv_pkg::DataW-1:0]  read_value_o,
  output logic [usv_pkg::CntOutW-1:0]       entry_count_o
);

  usv_pkg::usv_cmd_t  cmd;
  usv_pkg::usv_stat_t stat;

  usv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  usv_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .index_i       (index_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .done_o        (done_o)
  );

endmodule

FILE: sv/usv_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_ctrl
// Sequencer for add, remove and read requests; drives the datapath commands.
// ---------------------------------------------------------------------------
module usv_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic [usv_pkg::ActW-1:0]         action_i,
  input  usv_pkg::usv_stat_t               stat_i,
  output usv_pkg::usv_cmd_t                cmd_o,
  output logic                             busy
);

  usv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= usv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      usv_pkg::S_IDLE: begin
        if (start) begin
          unique case (action_i)
            usv_pkg::ACT_ADD:    state_d = usv_pkg::S_ADD_SCAN;
            usv_pkg::ACT_REMOVE: state_d = usv_pkg::S_REM_SCAN;
            usv_pkg::ACT_READ: begin
              if (!stat_i.empty) state_d = usv_pkg::S_RD_ADDR;
            end
            default: state_d = usv_pkg::S_IDLE;
          endcase
        end
      end
      usv_pkg::S_ADD_SCAN: begin
        if (stat_i.hit || stat_i.scan_done) state_d = usv_pkg::S_IDLE;
      end
      usv_pkg::S_REM_SCAN: begin
        if (stat_i.hit)                state_d = usv_pkg::S_REM_LAST;
        else if (stat_i.scan_done)     state_d = usv_pkg::S_IDLE;
      end
      usv_pkg::S_REM_LAST: state_d = usv_pkg::S_REM_MOVE;
      usv_pkg::S_REM_MOVE: state_d = usv_pkg::S_IDLE;
      usv_pkg::S_RD_ADDR:  state_d = usv_pkg::S_RD_DATA;
      usv_pkg::S_RD_DATA:  state_d = usv_pkg::S_IDLE;
      default:             state_d = usv_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.addr_sel   = usv_pkg::ADDR_SCAN;
    cmd_o.wr_sel     = usv_pkg::WR_APPEND;
    cmd_o.res_status = usv_pkg::STAT_OK;
    unique case (state_q)
      usv_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (action_i)
            usv_pkg::ACT_ADD, usv_pkg::ACT_REMOVE: ;
            usv_pkg::ACT_READ: begin
              if (stat_i.empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = usv_pkg::STAT_EMPTY;
              end
            end
            // unused code: report ok, nothing changes
            default: cmd_o.res_load = 1'b1;
          endcase
        end
      end
      usv_pkg::S_ADD_SCAN: begin
        cmd_o.scan = 1'b1;
        // hit needs a valid compare, scan_done needs none: never both
        if (stat_i.hit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = usv_pkg::STAT_DUP;
        end else if (stat_i.scan_done) begin
          cmd_o.res_load = 1'b1;
          if (stat_i.full) begin
            cmd_o.res_status = usv_pkg::STAT_FULL;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = usv_pkg::WR_APPEND;
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      usv_pkg::S_REM_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.pos_load = 1'b1;
        end else if (stat_i.scan_done) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = usv_pkg::STAT_NOTFOUND;
        end
      end
      usv_pkg::S_REM_LAST: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = usv_pkg::ADDR_LAST;
      end
      usv_pkg::S_REM_MOVE: begin
        // last entry fills the hole
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = usv_pkg::WR_MOVE;
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.res_load = 1'b1;
      end
      usv_pkg::S_RD_ADDR: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = usv_pkg::ADDR_INDEX;
      end
      usv_pkg::S_RD_DATA: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_data = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != usv_pkg::S_IDLE);

endmodule

FILE: sv/usv_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_dp
// Entry store, entry count, pipelined scan compare and result registers.
// ---------------------------------------------------------------------------
module usv_dp #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [usv_pkg::DataW-1:0]    value_i,
  input  logic signed [usv_pkg::IdxW-1:0]     index_i,
  input  usv_pkg::usv_cmd_t                   cmd_i,
  output usv_pkg::usv_stat_t                  stat_o,
  output logic [usv_pkg::StatW-1:0]           status_o,
  output logic signed [usv_pkg::DataW-1:0]    read_value_o,
  output logic [usv_pkg::CntOutW-1:0]         entry_count_o,
  output logic                                done_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > usv_pkg::IdxW - 1) ? CW : usv_pkg::IdxW - 1;

  logic [usv_pkg::DataW-1:0] entry_mem_q [CAPACITY];

  logic [usv_pkg::DataW-1:0] value_q;
  logic [usv_pkg::IdxW-1:0]  index_q;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             ptr_q, ptr_d;
  logic                      cmp_valid_q, cmp_valid_d;
  logic [AW-1:0]             cmp_idx_q;
  logic [usv_pkg::DataW-1:0] rd_data_q;
  logic [AW-1:0]             pos_q;
  usv_pkg::status_e          res_status_q;
  logic [usv_pkg::DataW-1:0] res_value_q;
  logic                      res_valid_q;

  logic                      issue_ok;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [usv_pkg::DataW-1:0] wr_data;
  logic [CW-1:0]             last_idx;
  logic [XW-1:0]             idx_ext;
  logic [XW-1:0]             cnt_ext;
  logic [AW-1:0]             read_addr;

  assign issue_ok = (ptr_q < count_q);
  assign last_idx = count_q - CW'(1);

  // read index clamp: negative to 0, past the end to the last entry
  assign idx_ext = XW'(index_q[usv_pkg::IdxW-2:0]);
  assign cnt_ext = XW'(count_q);
  always_comb begin
    priority if (index_q[usv_pkg::IdxW-1]) read_addr = '0;
    else if (idx_ext >= cnt_ext)           read_addr = AW'(last_idx);
    else                                   read_addr = AW'(idx_ext);
  end

  always_comb begin
    unique case (cmd_i.addr_sel)
      usv_pkg::ADDR_SCAN:  rd_addr = AW'(ptr_q);
      usv_pkg::ADDR_LAST:  rd_addr = AW'(last_idx);
      usv_pkg::ADDR_INDEX: rd_addr = read_addr;
      default:             rd_addr = AW'(ptr_q);
    endcase
  end

  assign rd_en = cmd_i.rd_en | (cmd_i.scan & issue_ok);

  always_comb begin
    unique case (cmd_i.wr_sel)
      usv_pkg::WR_APPEND: begin
        wr_addr = AW'(count_q);
        wr_data = value_q;
      end
      usv_pkg::WR_MOVE: begin
        wr_addr = pos_q;
        wr_data = rd_data_q;
      end
      default: begin
        wr_addr = AW'(count_q);
        wr_data = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= entry_mem_q[rd_addr];
    end
  end

  // scan pointer and compare stage
  always_comb begin
    ptr_d       = ptr_q;
    cmp_valid_d = cmp_valid_q;
    if (cmd_i.load) begin
      ptr_d       = '0;
      cmp_valid_d = 1'b0;
    end else if (cmd_i.scan) begin
      cmp_valid_d = issue_ok;
      if (issue_ok) ptr_d = ptr_q + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc)      count_d = count_q + CW'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      cmp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      cmp_valid_q <= cmp_valid_d;
      res_valid_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      index_q <= index_i;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= AW'(ptr_q);
    end
    if (cmd_i.pos_load) begin
      pos_q <= cmp_idx_q;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= cmd_i.res_data ? rd_data_q : '0;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CW'(CAPACITY));
  assign stat_o.hit       = cmp_valid_q && (rd_data_q == value_q);
  assign stat_o.scan_done = !issue_ok && !cmp_valid_q;

  assign status_o      = res_status_q;
  assign read_value_o  = res_value_q;
  assign entry_count_o = usv_pkg::CntOutW'(count_q);
  assign done_o        = res_valid_q;

endmodule

FILE: sv/usv_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_checker
// Port-level checks on the unique value set, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module usv_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic [usv_pkg::StatW-1:0]         status_o,
  input logic signed [usv_pkg::DataW-1:0]  read_value_o,
  input logic [usv_pkg::CntOutW-1:0]       entry_count_o
);

  logic [usv_pkg::CntOutW-1:0] cap_low;
  logic                        res_fail;
  logic                        res_empty;
  logic                        res_full;
  logic                        empty_zero;

  assign cap_low    = usv_pkg::CntOutW'(CAPACITY);
  assign res_fail   = done_o && (status_o != usv_pkg::STAT_OK);
  assign res_empty  = done_o && (status_o == usv_pkg::STAT_EMPTY);
  assign res_full   = done_o && (status_o == usv_pkg::STAT_FULL);
  assign empty_zero = (entry_count_o == '0) && (read_value_o == '0);

  // count only moves together with a result
  `USV_ASSERT(a_cnt_with_result, !$stable(entry_count_o) |-> done_o, "count moved alone")

  // a request either keeps the block busy or answers in the next cycle
  `USV_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done_o), "request dropped")

  // failed requests leave the entry count unchanged
  `USV_ASSERT(a_fail_no_change, res_fail |-> $stable(entry_count_o), "failure changed count")

  // empty status only with no entries and a zero read value
  `USV_ASSERT(a_empty_result, res_empty |-> empty_zero, "empty status inconsistent")

  // full status reports the whole store in use
  `USV_ASSERT(a_full_result, res_full |-> (entry_count_o == cap_low), "full with free entries")

endmodule

bind unique_value_set usv_checker #(.CAPACITY(CAPACITY)) u_usv_checker (.*);
